@@ src/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes for the sorted interval set unit: item structs,
// operation codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 24;
    localparam int CNT_W   = 25;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic               hit;
        logic [CNT_W-1:0]   least_above_first;
        logic [CNT_W-1:0]   member_count;
        logic               no_room;
    } res_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_POP,
        ST_LINK,
        ST_LINK_PREV,
        ST_FIN,
        ST_FIRST,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ src/sorted_interval_set_unit.sv @@
// Walk: one interval node per cycle. Throughput: one item at a time; an item
// holds the unit, with cmd_stall high, until its result is emitted. A stalled
// result keeps the unit in its output state and holds off the next item.
// Reset: control state clears at once; the sentinels are constants and the
// RAM contents need no clearing pass, so items are taken right after reset.
// ----------------------------------------------------------------------------
// sorted_interval_set_unit
// Set of integers kept as an ascending linked chain of disjoint intervals in
// a node RAM, with a free stack RAM for released nodes.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_interval_set_unit #(
    parameter int MAX_NODES  = 256,
    parameter int VALUE_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output      logic              cmd_stall,
    input  wire sis_pkg::cmd_item_t cmd,
    output      logic              res_valid,
    input  wire logic              res_stall,
    output      sis_pkg::res_item_t res
);

    import sis_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int VB     = VALUE_BITS;
    localparam int BW     = VB + 2;
    localparam int NODE_W = 2 * VB + NW;

    localparam logic signed [BW-1:0] SENT_POS = {2'b01, {VB{1'b0}}};
    localparam logic signed [BW-1:0] SENT_NEG = {2'b11, {VB{1'b0}}};
    localparam logic signed [BW-1:0] ONE_S    = BW'(1);
    localparam logic signed [BW-1:0] TWO_S    = BW'(2);
    localparam logic [NW-1:0]        HEAD_IDX = NW'(0);
    localparam logic [NW-1:0]        TAIL_IDX = NW'(1);
    localparam logic [NW:0]          DEPTH_C  = (NW+1)'(MAX_NODES);

    // RAM ports
    logic              node_we, node_re;
    logic [NW-1:0]     node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic              stk_we, stk_re;
    logic [NW-1:0]     stk_waddr, stk_raddr;
    logic [NW-1:0]     stk_wdata, stk_rdata;

    // control registers
    state_t           state_reg, state_next;
    logic [NW-1:0]    head_succ_reg, head_succ_next;
    logic [NW:0]      fd_reg, fd_next;
    logic [NW:0]      fresh_reg, fresh_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg, res_valid_next;

    // item work registers
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [VB-1:0]          x_reg, x_next;
    logic [NW-1:0]          pos_reg, pos_next;
    logic [NW-1:0]          prev_reg, prev_next;
    logic [NW-1:0]          pos_succ_reg, pos_succ_next;
    logic [NW-1:0]          idx_reg, idx_next;
    logic signed [BW-1:0]   pos_lo_reg, pos_lo_next;
    logic signed [BW-1:0]   pos_hi_reg, pos_hi_next;
    logic signed [BW-1:0]   prev_lo_reg, prev_lo_next;
    logic signed [BW-1:0]   prev_hi_reg, prev_hi_next;
    logic                   hit_reg, hit_next;
    logic                   no_room_reg, no_room_next;
    logic [CNT_W-1:0]       laf_reg, laf_next;
    res_item_t              res_reg, res_next;

    // decoded node word
    logic [VB-1:0]        rd_lo, rd_hi;
    logic [NW-1:0]        rd_succ;
    logic signed [BW-1:0] rd_lo_s, rd_hi_s, xs;
    logic [31:0]          cmd_v32, laf_sum;
    logic [NW:0]          fd_dec;

    sis_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    sis_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_free_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign rd_lo   = node_rdata[NODE_W-1 -: VB];
    assign rd_hi   = node_rdata[NW +: VB];
    assign rd_succ = node_rdata[NW-1:0];
    assign rd_lo_s = $signed({2'b00, rd_lo});
    assign rd_hi_s = $signed({2'b00, rd_hi});
    assign xs      = $signed({2'b00, x_reg});
    assign cmd_v32 = 32'(cmd.value);
    assign laf_sum = 32'(rd_hi) + 32'd1;
    assign fd_dec  = fd_reg - (NW+1)'(1);

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // next state, RAM requests and register updates
    always_comb
    begin
        state_next     = state_reg;
        head_succ_next = head_succ_reg;
        fd_next        = fd_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && res_stall;
        mode_next      = mode_reg;
        x_next         = x_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        pos_succ_next  = pos_succ_reg;
        idx_next       = idx_reg;
        pos_lo_next    = pos_lo_reg;
        pos_hi_next    = pos_hi_reg;
        prev_lo_next   = prev_lo_reg;
        prev_hi_next   = prev_hi_reg;
        hit_next       = hit_reg;
        no_room_next   = no_room_reg;
        laf_next       = laf_reg;
        res_next       = res_reg;

        node_we    = 1'b0;
        node_waddr = pos_reg;
        node_wdata = {x_reg, x_reg, pos_reg};
        node_re    = 1'b0;
        node_raddr = head_succ_reg;
        stk_we     = 1'b0;
        stk_waddr  = fd_reg[NW-1:0];
        stk_wdata  = pos_reg;
        stk_re     = 1'b0;
        stk_raddr  = fd_dec[NW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next    = cmd.mode;
                    x_next       = cmd_v32[VB-1:0];
                    hit_next     = 1'b0;
                    no_room_next = 1'b0;
                    prev_next    = HEAD_IDX;
                    prev_lo_next = SENT_NEG;
                    prev_hi_next = SENT_NEG;
                    pos_next     = head_succ_reg;
                    pos_lo_next  = SENT_POS;
                    pos_hi_next  = SENT_POS;
                    if (cmd.mode == MODE_QUERY || cmd.mode == MODE_INSERT)
                    begin
                        // start the walk at the first real node
                        if (head_succ_reg > TAIL_IDX)
                        begin
                            node_re    = 1'b1;
                            node_raddr = head_succ_reg;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_DECIDE;
                        end
                    end
                    else if (cmd.mode == MODE_CLEAR)
                    begin
                        head_succ_next = TAIL_IDX;
                        fd_next        = '0;
                        fresh_next     = (NW+1)'(2);
                        count_next     = '0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_WALK:
            begin
                // one node per cycle: skip it while its upper end is below x
                if (rd_hi_s < xs)
                begin
                    prev_next    = pos_reg;
                    prev_lo_next = rd_lo_s;
                    prev_hi_next = rd_hi_s;
                    pos_next     = rd_succ;
                    if (rd_succ > TAIL_IDX)
                    begin
                        node_re    = 1'b1;
                        node_raddr = rd_succ;
                    end
                    else
                    begin
                        pos_lo_next = SENT_POS;
                        pos_hi_next = SENT_POS;
                        state_next  = ST_DECIDE;
                    end
                end
                else
                begin
                    pos_lo_next   = rd_lo_s;
                    pos_hi_next   = rd_hi_s;
                    pos_succ_next = rd_succ;
                    state_next    = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_FIN;
                if (mode_reg != MODE_INSERT)
                begin
                    hit_next = (pos_lo_reg <= xs);
                end
                else if (pos_lo_reg <= xs)
                begin
                    hit_next = 1'b0;
                end
                else if (pos_reg > TAIL_IDX && prev_hi_reg == pos_lo_reg - TWO_S)
                begin
                    // value fills the gap: merge pos into prev, release pos
                    node_we    = 1'b1;
                    node_waddr = prev_reg;
                    node_wdata = {prev_lo_reg[VB-1:0], pos_hi_reg[VB-1:0], pos_succ_reg};
                    if (fd_reg < DEPTH_C)
                    begin
                        stk_we    = 1'b1;
                        stk_waddr = fd_reg[NW-1:0];
                        stk_wdata = pos_reg;
                        fd_next   = fd_reg + (NW+1)'(1);
                    end
                    hit_next   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (prev_hi_reg == xs - ONE_S)
                begin
                    // extend prev upward
                    node_we    = 1'b1;
                    node_waddr = prev_reg;
                    node_wdata = {prev_lo_reg[VB-1:0], x_reg, pos_reg};
                    hit_next   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (pos_reg > TAIL_IDX && pos_lo_reg == xs + ONE_S)
                begin
                    // extend pos downward
                    node_we    = 1'b1;
                    node_waddr = pos_reg;
                    node_wdata = {x_reg, pos_hi_reg[VB-1:0], pos_succ_reg};
                    hit_next   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (fd_reg != '0)
                begin
                    // singleton from the free stack
                    stk_re     = 1'b1;
                    stk_raddr  = fd_dec[NW-1:0];
                    fd_next    = fd_dec;
                    state_next = ST_POP;
                end
                else if (fresh_reg < DEPTH_C)
                begin
                    // singleton from fresh storage
                    idx_next   = fresh_reg[NW-1:0];
                    fresh_next = fresh_reg + (NW+1)'(1);
                    state_next = ST_LINK;
                end
                else
                begin
                    no_room_next = 1'b1;
                end
            end

            ST_POP:
            begin
                idx_next   = stk_rdata;
                state_next = ST_LINK;
            end

            ST_LINK:
            begin
                node_we    = 1'b1;
                node_waddr = idx_reg;
                node_wdata = {x_reg, x_reg, pos_reg};
                hit_next   = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (prev_reg == HEAD_IDX)
                begin
                    head_succ_next = idx_reg;
                    state_next     = ST_FIN;
                end
                else
                begin
                    state_next = ST_LINK_PREV;
                end
            end

            ST_LINK_PREV:
            begin
                node_we    = 1'b1;
                node_waddr = prev_reg;
                node_wdata = {prev_lo_reg[VB-1:0], prev_hi_reg[VB-1:0], idx_reg};
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                // fetch the first interval for its upper end
                if (head_succ_reg > TAIL_IDX)
                begin
                    node_re    = 1'b1;
                    node_raddr = head_succ_reg;
                    state_next = ST_FIRST;
                end
                else
                begin
                    laf_next   = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_FIRST:
            begin
                laf_next   = laf_sum[CNT_W-1:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.hit               = hit_reg;
                    res_next.least_above_first = laf_reg;
                    res_next.member_count      = count_reg;
                    res_next.no_room           = no_room_reg;
                    res_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_succ_reg <= TAIL_IDX;
            fd_reg        <= '0;
            fresh_reg     <= (NW+1)'(2);
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_succ_reg <= head_succ_next;
            fd_reg        <= fd_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        x_reg        <= x_next;
        pos_reg      <= pos_next;
        prev_reg     <= prev_next;
        pos_succ_reg <= pos_succ_next;
        idx_reg      <= idx_next;
        pos_lo_reg   <= pos_lo_next;
        pos_hi_reg   <= pos_hi_next;
        prev_lo_reg  <= prev_lo_next;
        prev_hi_reg  <= prev_hi_next;
        hit_reg      <= hit_next;
        no_room_reg  <= no_room_next;
        laf_reg      <= laf_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

@@ src/sis_ram.sv @@
// ----------------------------------------------------------------------------
// sis_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
